// ===== rtl/core/wdmlp_pkg.sv =====
// wdmlp_pkg: shared types, constants and weight functions for the windowed
// decay mean linear predictor. Depends on nothing; used by every rtl/core file.
package wdmlp_pkg;

    // default geometry
    localparam int unsigned WINDOW_TAPS = 5;
    localparam int unsigned SAMPLE_BITS = 16;

    // fixed formats
    localparam int unsigned FILL_W   = 5;   // holds up to 31 taps
    localparam int unsigned WEIGHT_W = 17;  // Q1.16 tap weight
    localparam int unsigned RECIP_W  = 17;  // Q16 reciprocal of weight sum
    localparam int unsigned DATA_W   = 32;  // gain, offset, results

    localparam logic [63:0] ONE_Q16   = 64'd65536;
    localparam logic [63:0] DECAY_Q16 = 64'd45875;  // 0.7 in Q0.16
    localparam logic [63:0] HALF_Q16  = 64'd32768;

    // opcodes carried in tuser
    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_ADD     = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    // register indexes
    localparam logic REG_GAIN   = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    // control half of the token walking the cell chain
    typedef struct packed {
        logic              vld;
        logic [FILL_W-1:0] fill;
    } ctl_t;

    // w(0) = 1.0, w(k+1) = round(w(k) * 0.7)
    function automatic logic [WEIGHT_W-1:0] tap_weight(input int unsigned k);
        logic [63:0] w;
        w = ONE_Q16;
        for (int unsigned i = 0; i < k; i++)
        begin
            w = (w * DECAY_Q16 + HALF_Q16) >> 16;
        end
        return w[WEIGHT_W-1:0];
    endfunction

    // sum of the first n tap weights
    function automatic logic [63:0] tap_weight_total(input int unsigned n);
        logic [63:0] s;
        s = 64'd0;
        for (int unsigned i = 0; i < n; i++)
        begin
            s = s + {{(64-WEIGHT_W){1'b0}}, tap_weight(i)};
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/windowed_decay_mean_linear_predictor_top.sv =====
// windowed_decay_mean_linear_predictor_top: stream top level with config
// registers, fill counter and the tap chain. Depends on wdmlp_pkg,
// wdmlp_cell and wdmlp_post.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample; tuser: opcode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: prediction, mean; tuser: saturated
// cfg       in   cfg_we (no wait)              cfg_index, cfg_data
//
// Add-only, clear and unused-opcode transactions leave the input ready.
// A predict transaction blocks the input until its token has passed the
// gain stage: the token walks the tap chain one cell per cycle, then four post
// stages (split multiply, mean, gain multiply, output register).
// A result may wait in the output register while new input is accepted;
// a stalled output holds only the gain stage behind it.
// Reset clears the window, the fill count, gain to 1.0 and offset to 0.
module windowed_decay_mean_linear_predictor_top #(
    parameter int unsigned WINDOW_TAPS = wdmlp_pkg::WINDOW_TAPS,
    parameter int unsigned SAMPLE_BITS = wdmlp_pkg::SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample, zero pad
    input  logic [1:0]                             s_axis_tuser,  // opcode
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [63:0]                            m_axis_tdata,  // prediction, smoothed_mean
    output logic                                   m_axis_tuser,  // saturated
    // configuration
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [wdmlp_pkg::DATA_W-1:0]           cfg_data
);

    localparam int unsigned ACC_W  = SAMPLE_BITS + 18;
    localparam int unsigned FILL_W = wdmlp_pkg::FILL_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_TAPS);

    logic signed [31:0]      gain_reg, gain_next;
    logic signed [31:0]      offset_reg, offset_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [FILL_W-1:0]       fill_inc;

    // token launch register feeding tap 0
    wdmlp_pkg::ctl_t         start_ctl_reg, start_ctl_next;

    logic                    accept;
    logic                    shift_en;
    logic                    clear;
    logic                    post_busy;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    // chain links: index 0 is the launch register, K+1 is the output of tap K
    wdmlp_pkg::ctl_t                 ctl_chain   [0:WINDOW_TAPS];
    logic signed [ACC_W-1:0]         acc_chain   [0:WINDOW_TAPS];
    logic [wdmlp_pkg::RECIP_W-1:0]   recip_chain [0:WINDOW_TAPS];
    logic signed [SAMPLE_BITS-1:0]   samp_chain  [0:WINDOW_TAPS-1];
    logic [WINDOW_TAPS-1:0]          tap_busy;

    logic signed [31:0]      prediction;
    logic signed [31:0]      smoothed_mean;

    assign in_sample     = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = !(start_ctl_reg.vld || (|tap_busy) || post_busy);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // config writes
    always_comb
    begin
        gain_next   = gain_reg;
        offset_next = offset_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wdmlp_pkg::REG_GAIN:   gain_next   = cfg_data;
                wdmlp_pkg::REG_OFFSET: offset_next = cfg_data;
                default:               gain_next   = gain_reg;
            endcase
        end
    end

    // opcode decode, fill count, token launch
    assign fill_inc = (fill_reg < FILL_MAX) ? fill_reg + 1'b1 : fill_reg;

    always_comb
    begin
        shift_en       = 1'b0;
        clear          = 1'b0;
        fill_next      = fill_reg;
        start_ctl_next = '0;
        if (accept)
        begin
            case (s_axis_tuser)
                wdmlp_pkg::OP_PREDICT:
                begin
                    shift_en            = 1'b1;
                    fill_next           = fill_inc;
                    start_ctl_next.vld  = 1'b1;
                    start_ctl_next.fill = fill_inc;
                end
                wdmlp_pkg::OP_ADD:
                begin
                    shift_en  = 1'b1;
                    fill_next = fill_inc;
                end
                wdmlp_pkg::OP_CLEAR:
                begin
                    clear     = 1'b1;
                    fill_next = '0;
                end
                default:
                begin
                    shift_en = 1'b0;    // unused opcode: dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= 32'sd65536;
            offset_reg    <= '0;
            fill_reg      <= '0;
            start_ctl_reg <= '0;
        end
        else
        begin
            gain_reg      <= gain_next;
            offset_reg    <= offset_next;
            fill_reg      <= fill_next;
            start_ctl_reg <= start_ctl_next;
        end
    end

    assign ctl_chain[0]   = start_ctl_reg;
    assign acc_chain[0]   = '0;
    assign recip_chain[0] = '0;

    // tap chain, newest sample in tap 0
    for (genvar k = 0; k < WINDOW_TAPS; k++)
    begin : g_tap
        logic signed [SAMPLE_BITS-1:0] tap_in;
        if (k == 0)
        begin : g_first
            assign tap_in = in_sample;
        end
        else
        begin : g_rest
            assign tap_in = samp_chain[k-1];
        end

        wdmlp_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .TAP         (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (shift_en),
            .clear      (clear),
            .sample_in  (tap_in),
            .sample_out (samp_chain[k]),
            .ctl_in     (ctl_chain[k]),
            .acc_in     (acc_chain[k]),
            .recip_in   (recip_chain[k]),
            .ctl_out    (ctl_chain[k+1]),
            .acc_out    (acc_chain[k+1]),
            .recip_out  (recip_chain[k+1])
        );

        assign tap_busy[k] = ctl_chain[k+1].vld;
    end

    wdmlp_post #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .gain          (gain_reg),
        .offset        (offset_reg),
        .ctl_in        (ctl_chain[WINDOW_TAPS]),
        .acc_in        (acc_chain[WINDOW_TAPS]),
        .recip_in      (recip_chain[WINDOW_TAPS]),
        .busy          (post_busy),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .prediction    (prediction),
        .smoothed_mean (smoothed_mean),
        .saturated     (m_axis_tuser)
    );

    assign m_axis_tdata = {smoothed_mean, prediction};

    // fill count never passes the window depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count above window depth");

    // at most one token in flight between launch and output register
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({start_ctl_reg.vld, tap_busy, post_busy}))
        else $error("more than one token in flight");

    // a predict transaction blocks the input on the next cycle
    a_predict_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_axis_tuser == wdmlp_pkg::OP_PREDICT) |=> !s_axis_tready)
        else $error("input ready right after predict");

    // a clear empties the count and the oldest tap
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_axis_tuser == wdmlp_pkg::OP_CLEAR)
        |=> (fill_reg == '0) && (samp_chain[WINDOW_TAPS-1] == '0))
        else $error("clear left window state");

    // add-only grows the count by one until full
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (s_axis_tuser == wdmlp_pkg::OP_ADD) && (fill_reg < FILL_MAX)
        |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count did not advance");

endmodule

// ===== rtl/core/wdmlp_cell.sv =====
// wdmlp_cell: one window tap. Holds one sample, shifts it to the next tap,
// and adds its weighted sample to the passing token when its fill covers this tap. Depends on wdmlp_pkg.
module wdmlp_cell #(
    parameter int unsigned SAMPLE_BITS = wdmlp_pkg::SAMPLE_BITS,
    parameter int unsigned TAP         = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift_en,
    input  logic                                clear,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    output logic signed [SAMPLE_BITS-1:0]       sample_out,
    input  wdmlp_pkg::ctl_t                     ctl_in,
    input  logic signed [SAMPLE_BITS+17:0]      acc_in,
    input  logic [wdmlp_pkg::RECIP_W-1:0]       recip_in,
    output wdmlp_pkg::ctl_t                     ctl_out,
    output logic signed [SAMPLE_BITS+17:0]      acc_out,
    output logic [wdmlp_pkg::RECIP_W-1:0]       recip_out
);

    localparam int unsigned ACC_W = SAMPLE_BITS + 18;
    localparam logic [wdmlp_pkg::WEIGHT_W-1:0] WEIGHT = wdmlp_pkg::tap_weight(TAP);
    localparam logic [63:0] SUM        = wdmlp_pkg::tap_weight_total(TAP + 1);
    localparam logic [63:0] RECIP_FULL = (64'h1_0000_0000 + SUM / 64'd2) / SUM;
    localparam logic [wdmlp_pkg::RECIP_W-1:0] RECIP = RECIP_FULL[wdmlp_pkg::RECIP_W-1:0];
    localparam logic [wdmlp_pkg::FILL_W-1:0] TAP_IDX  = wdmlp_pkg::FILL_W'(TAP);
    localparam logic [wdmlp_pkg::FILL_W-1:0] TAP_FILL = wdmlp_pkg::FILL_W'(TAP + 1);

    logic signed [SAMPLE_BITS-1:0]   sample_reg, sample_next;
    wdmlp_pkg::ctl_t                 ctl_reg;
    logic signed [ACC_W-1:0]         acc_reg, acc_next;
    logic [wdmlp_pkg::RECIP_W-1:0]   recip_reg, recip_next;
    logic signed [ACC_W-1:0]         prod;

    always_comb
    begin
        sample_next = sample_reg;
        if (clear)
        begin
            sample_next = '0;
        end
        else if (shift_en)
        begin
            sample_next = sample_in;
        end
    end

    assign prod = $signed(sample_reg) * $signed({1'b0, WEIGHT});

    always_comb
    begin
        acc_next   = (ctl_in.fill > TAP_IDX) ? acc_in + prod : acc_in;
        recip_next = (ctl_in.fill == TAP_FILL) ? RECIP : recip_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            ctl_reg    <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            ctl_reg    <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        recip_reg <= recip_next;
    end

    assign sample_out = sample_reg;
    assign ctl_out    = ctl_reg;
    assign acc_out    = acc_reg;
    assign recip_out  = recip_reg;

endmodule

// ===== rtl/core/wdmlp_post.sv =====
// wdmlp_post: normalization, gain and offset stages plus the output register.
// Takes the finished token from the cell chain. Depends on wdmlp_pkg.
module wdmlp_post #(
    parameter int unsigned SAMPLE_BITS = wdmlp_pkg::SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [wdmlp_pkg::DATA_W-1:0]   gain,
    input  logic signed [wdmlp_pkg::DATA_W-1:0]   offset,
    input  wdmlp_pkg::ctl_t                       ctl_in,
    input  logic signed [SAMPLE_BITS+17:0]        acc_in,
    input  logic [wdmlp_pkg::RECIP_W-1:0]         recip_in,
    output logic                                  busy,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [wdmlp_pkg::DATA_W-1:0]   prediction,
    output logic signed [wdmlp_pkg::DATA_W-1:0]   smoothed_mean,
    output logic                                  saturated
);

    localparam int unsigned ACC_W = SAMPLE_BITS + 18;
    localparam int unsigned HI_W  = ACC_W - 17;                   // upper acc slice
    localparam int unsigned HI_PW = HI_W + wdmlp_pkg::RECIP_W + 1;
    localparam int unsigned LO_PW = 17 + wdmlp_pkg::RECIP_W;
    localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] RND   = 64'sd32768;

    // stage 1: split product acc * recip
    logic                    m1_vld_reg;
    logic signed [HI_PW-1:0] p_hi_reg, p_hi_next;
    logic [LO_PW-1:0]        p_lo_reg, p_lo_next;
    // stage 2: mean
    logic                    m2_vld_reg;
    logic signed [31:0]      mean2_reg, mean2_next;
    // stage 3: gain product
    logic                    m3_vld_reg, m3_vld_next;
    logic signed [63:0]      gp_reg, gp_next;
    logic signed [31:0]      mean3_reg, mean3_next;
    // output register
    logic                    out_vld_reg, out_vld_next;
    logic signed [31:0]      pred_reg, pred_next;
    logic signed [31:0]      mean_out_reg;
    logic                    sat_reg, sat_next;

    logic signed [63:0]      full;
    logic signed [63:0]      m64;
    logic signed [63:0]      p64;
    logic                    stall;
    logic                    load_out;

    assign p_hi_next = $signed(acc_in[ACC_W-1:17]) * $signed({1'b0, recip_in});
    assign p_lo_next = acc_in[16:0] * recip_in;

    always_comb
    begin
        full = {{(64-HI_PW-17){p_hi_reg[HI_PW-1]}}, p_hi_reg, 17'b0}
             + $signed({{(64-LO_PW){1'b0}}, p_lo_reg}) + RND;
        m64  = full >>> 16;
        if (m64 > MAX32)
        begin
            mean2_next = 32'sh7FFF_FFFF;
        end
        else if (m64 < MIN32)
        begin
            mean2_next = -32'sh8000_0000;
        end
        else
        begin
            mean2_next = m64[31:0];
        end
    end

    assign stall    = out_vld_reg && !out_ready;
    assign load_out = m3_vld_reg && !stall;

    always_comb
    begin
        gp_next     = gp_reg;
        mean3_next  = mean3_reg;
        m3_vld_next = m2_vld_reg | (m3_vld_reg & stall);
        if (m2_vld_reg)
        begin
            gp_next    = gain * mean2_reg;
            mean3_next = mean2_reg;
        end
    end

    // the whole sum stays signed so the shift floors negative products
    always_comb
    begin
        p64 = ((gp_reg + RND) >>> 16) + $signed({{32{offset[31]}}, offset});
        if (p64 > MAX32)
        begin
            pred_next = 32'sh7FFF_FFFF;
            sat_next  = 1'b1;
        end
        else if (p64 < MIN32)
        begin
            pred_next = -32'sh8000_0000;
            sat_next  = 1'b1;
        end
        else
        begin
            pred_next = p64[31:0];
            sat_next  = 1'b0;
        end
        out_vld_next = load_out | stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg  <= ctl_in.vld;
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m3_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_hi_reg  <= p_hi_next;
        p_lo_reg  <= p_lo_next;
        mean2_reg <= mean2_next;
        gp_reg    <= gp_next;
        mean3_reg <= mean3_next;
        if (load_out)
        begin
            pred_reg     <= pred_next;
            mean_out_reg <= mean3_reg;
            sat_reg      <= sat_next;
        end
    end

    assign busy          = m1_vld_reg | m2_vld_reg | m3_vld_reg;
    assign out_valid     = out_vld_reg;
    assign prediction    = pred_reg;
    assign smoothed_mean = mean_out_reg;
    assign saturated     = sat_reg;

endmodule
